>>> hdl/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, register codes and fixed-point helpers shared by the stereo
// feedback delay modules.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_DELAY_LEN = 2'd0;
  localparam logic [1:0] REG_FEEDBACK  = 2'd1;
  localparam logic [1:0] REG_DRY_MIX   = 2'd2;

  // reset values and unity gain (Q1.16)
  localparam logic [15:0] RST_DELAY_LEN = 16'd24000;
  localparam logic [16:0] RST_FEEDBACK  = 17'd32768;
  localparam logic [16:0] RST_DRY_MIX   = 17'd32768;
  localparam logic [16:0] UNITY         = 17'd65536;

  // one classified input item
  typedef struct packed {
    logic               bad;
    logic               chan;
    logic signed [15:0] x;
  } item_t;

  // settings seen by the back end
  typedef struct packed {
    logic [15:0] delay_len;
    logic [16:0] fb_gain;
    logic [16:0] dry_gain;
    logic        pos_clr;
  } cfg_t;

  // the two mix products of one item
  typedef struct packed {
    logic signed [33:0] d_prod;
    logic signed [33:0] x_prod;
  } mix_t;

  // gain clamped to unity
  function automatic logic [16:0] eff_gain(input logic [16:0] g);
    return (g > UNITY) ? UNITY : g;
  endfunction

  // round to nearest (ties up), drop 16 fraction bits, saturate to 16 bits
  function automatic logic signed [15:0] round_sat16(input logic signed [35:0] p);
    logic signed [35:0] t;
    logic signed [19:0] q;
    t = p + 36'sd32768;
    q = 20'(t >>> 16);
    if (q > 20'sd32767) begin
      return 16'sd32767;
    end else if (q < -20'sd32768) begin
      return -16'sd32768;
    end
    return 16'(q);
  endfunction

endpackage

>>> hdl/sfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_front
// Input side: takes samples, marks channels out of range and holds them in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sfd_front #(
  parameter int CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                chan,
  input  logic signed [15:0]  sample_in,
  input  logic                clr_busy,
  output logic                q_valid,
  input  logic                q_ready,
  output sfd_pkg::item_t      q_item
);

  sfd_pkg::item_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;
  sfd_pkg::item_t item_in;

  // classify the incoming item
  always_comb begin
    item_in.bad  = (32'(chan) >= 32'(CHANNELS));
    item_in.chan = chan;
    item_in.x    = sample_in;
  end

  // no transfer while the delay store is being cleared
  assign in_ready = (count != 2'd2) && !clr_busy;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = entries[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> hdl/sfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_back
// Delay store, write positions and the feedback update. Each good item reads
// the entry at its write position, then the oldest entry, writes back the
// fed-back value and forms the two mix products; a bad item gives zeros.
// ----------------------------------------------------------------------------
module sfd_back #(
  parameter int MAX_DELAY = 32768,
  parameter int CHANNELS  = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  sfd_pkg::cfg_t  cfg,
  input  logic           q_valid,
  output logic           q_ready,
  input  sfd_pkg::item_t q_item,
  output logic           clr_busy,
  output logic           mix_valid,
  input  logic           mix_ready,
  output sfd_pkg::mix_t  mix_data
);

  // only channels 0 and 1 can be addressed by the one-bit channel field
  localparam int PD = (CHANNELS < 2) ? 1 : 2;
  localparam int MD = PD * MAX_DELAY;
  localparam int AW = $clog2(MD);
  localparam int PW = $clog2(MAX_DELAY);
  localparam int LW = $clog2(MAX_DELAY + 1);

  localparam logic [2:0] S_CLR = 3'd0;
  localparam logic [2:0] S_RD  = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_WR  = 3'd3;
  localparam logic [2:0] S_MIX = 3'd4;

  logic [2:0]         state;
  logic [AW-1:0]      clr_cnt;
  logic [PW-1:0]      pos [PD];

  // per-item registers
  sfd_pkg::item_t     item_r;
  logic [AW-1:0]      wa;
  logic [AW-1:0]      ra;
  logic               same;
  logic signed [34:0] prod_fb;
  logic signed [15:0] entry_r;

  // delay store
  logic signed [15:0] mem [MD];
  logic signed [15:0] rdata;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [15:0] wdata;
  logic               re;
  logic [AW-1:0]      raddr;

  // position arithmetic
  logic [LW-1:0]      eff_len;
  logic [PW-1:0]      w_raw;
  logic [PW-1:0]      w;
  logic [LW-1:0]      r_ext;
  logic [PW-1:0]      r;
  logic [AW-1:0]      base;

  logic signed [16:0] fb_sum;
  logic signed [17:0] fb_s;
  logic signed [15:0] delayed;
  logic [16:0]        dry_eff;
  logic signed [17:0] dry_s;
  logic signed [17:0] wet_s;

  // effective delay length, clamped to 1..MAX_DELAY
  always_comb begin
    if (cfg.delay_len == 16'd0) begin
      eff_len = LW'(1);
    end else if ({16'd0, cfg.delay_len} > 32'(MAX_DELAY)) begin
      eff_len = LW'(MAX_DELAY);
    end else begin
      eff_len = LW'(cfg.delay_len);
    end
  end

  // write and read positions of the item at the queue head
  always_comb begin
    w_raw = pos[q_item.chan];
    w     = (LW'(w_raw) >= eff_len) ? '0 : w_raw;
    r_ext = LW'(w) + LW'(1);
    r     = (r_ext >= eff_len) ? '0 : PW'(r_ext);
    base  = q_item.chan ? AW'(MAX_DELAY) : '0;
  end

  assign q_ready   = (state == S_RD);
  assign clr_busy  = (state == S_CLR);
  assign mix_valid = (state == S_MIX);

  // feedback product operands
  assign fb_sum = 17'(rdata) + 17'(item_r.x);
  assign fb_s   = signed'({1'b0, cfg.fb_gain});

  // mix products; the oldest entry is the new one when the length is one
  always_comb begin
    dry_eff = sfd_pkg::eff_gain(cfg.dry_gain);
    dry_s   = signed'({1'b0, dry_eff});
    wet_s   = signed'({1'b0, sfd_pkg::UNITY - dry_eff});
    delayed = same ? entry_r : rdata;
    if (item_r.bad) begin
      mix_data.d_prod = '0;
      mix_data.x_prod = '0;
    end else begin
      mix_data.d_prod = delayed * wet_s;
      mix_data.x_prod = item_r.x * dry_s;
    end
  end

  // store port control
  always_comb begin
    we    = 1'b0;
    waddr = wa;
    wdata = sfd_pkg::round_sat16(36'(prod_fb));
    re    = 1'b0;
    raddr = ra;
    unique case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
      end
      S_RD: begin
        re    = q_valid;
        raddr = base + AW'(w);
      end
      S_MUL: begin
        re = 1'b1;
      end
      S_WR: begin
        we = !item_r.bad;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      for (int i = 0; i < PD; i++) begin
        pos[i] <= '0;
      end
    end else begin
      if (cfg.pos_clr) begin
        for (int i = 0; i < PD; i++) begin
          pos[i] <= '0;
        end
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MD - 1)) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          if (q_valid) begin
            if (!q_item.bad) begin
              pos[q_item.chan] <= r;
              state            <= S_MUL;
            end else begin
              state <= S_MIX;
            end
          end
        end
        S_MUL: begin
          state <= S_WR;
        end
        S_WR: begin
          state <= S_MIX;
        end
        S_MIX: begin
          if (mix_ready) begin
            state <= S_RD;
          end
        end
        default: begin
          state <= S_RD;
        end
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (state == S_RD && q_valid) begin
      item_r <= q_item;
      wa     <= base + AW'(w);
      ra     <= base + AW'(r);
      same   <= (r == w);
    end
    if (state == S_MUL) begin
      prod_fb <= fb_sum * fb_s;
    end
    if (state == S_WR) begin
      entry_r <= wdata;
    end
  end

endmodule

>>> hdl/sfd_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_mix
// Output side: registers the mix products, then adds, rounds and saturates
// into the output register.
// ----------------------------------------------------------------------------
module sfd_mix (
  input  logic               clk,
  input  logic               rst,
  input  logic               mix_valid,
  output logic               mix_ready,
  input  sfd_pkg::mix_t      mix_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out
);

  sfd_pkg::mix_t p_reg;
  logic          p_valid;
  logic          out_load;

  assign out_load  = p_valid && (!out_valid || out_ready);
  assign mix_ready = !p_valid || out_load;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (mix_ready) begin
      p_valid <= mix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_ready && mix_valid) begin
      p_reg <= mix_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= sfd_pkg::round_sat16(36'(p_reg.d_prod) + 36'(p_reg.x_prod));
    end
  end

endmodule

>>> hdl/stereo_feedback_delay_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_top
// Two-channel feedback delay with dry/wet mix, Q1.15 samples, Q1.16 gains.
// ----------------------------------------------------------------------------
// After reset the whole delay store is cleared one entry a cycle; in_ready
// stays low until then while configuration writes are still taken. Then the
// back end takes one sample at a time through the single-port delay store
// sequence (read the write position, multiply while reading the oldest
// entry, write back; bad-channel samples skip it) and takes no new sample
// until the mix side accepts the products of the last; a two-entry input
// queue and a product stage plus output register let both sides stall
// independently. A result passes the input queue, the store sequence, the
// product stage and the output register; items ahead and a stalled receiver delay it.
module stereo_feedback_delay_top #(
  parameter int MAX_DELAY = 32768,
  parameter int CHANNELS  = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               chan,
  input  logic signed [15:0] sample_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  logic [15:0]    delay_len;
  logic [16:0]    fb_gain;
  logic [16:0]    dry_gain;
  logic           cfg_we;
  sfd_pkg::cfg_t  cfg;
  logic           clr_busy;
  logic           q_valid;
  logic           q_ready;
  sfd_pkg::item_t q_item;
  logic           mix_valid;
  logic           mix_ready;
  sfd_pkg::mix_t  mix_data;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_len <= sfd_pkg::RST_DELAY_LEN;
      fb_gain   <= sfd_pkg::RST_FEEDBACK;
      dry_gain  <= sfd_pkg::RST_DRY_MIX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfd_pkg::REG_DELAY_LEN: delay_len <= cfg_data[15:0];
        sfd_pkg::REG_FEEDBACK:  fb_gain   <= cfg_data;
        sfd_pkg::REG_DRY_MIX:   dry_gain  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.delay_len = delay_len;
    cfg.fb_gain   = sfd_pkg::eff_gain(fb_gain);
    cfg.dry_gain  = dry_gain;
    cfg.pos_clr   = cfg_we && (cfg_index == sfd_pkg::REG_DELAY_LEN);
  end

  sfd_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .chan     (chan),
    .sample_in(sample_in),
    .clr_busy (clr_busy),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  sfd_back #(
    .MAX_DELAY(MAX_DELAY),
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .clr_busy (clr_busy),
    .mix_valid(mix_valid),
    .mix_ready(mix_ready),
    .mix_data (mix_data)
  );

  sfd_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .mix_valid (mix_valid),
    .mix_ready (mix_ready),
    .mix_data  (mix_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out)
  );

endmodule

>>> tb/sv/delay_mix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delay_mix_checker
// Watches the sample, result and register channels of the stereo feedback
// delay. It keeps its own copy of both delay lines and of the settings,
// predicts the mixed sample for every input transfer and compares each
// output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module delay_mix_checker #(
  parameter int MAX_DELAY = 32768,
  parameter int CHANNELS  = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               chan,
  input  logic signed [15:0] sample_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] sample_out,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 mismatch_count,
  output int                 outstanding
);

  localparam int STORE_DEPTH = MAX_DELAY * CHANNELS;

  // shadow delay lines, write positions and settings
  logic signed [15:0] echo_store [STORE_DEPTH];
  int unsigned        echo_pos [CHANNELS];
  logic [15:0]        len_reg;
  logic [16:0]        fb_reg;
  logic [16:0]        dry_reg;

  // mixed samples still owed by the block, oldest first
  logic signed [15:0] mix_expected [$];

  // round to nearest with ties upwards, drop 16 fraction bits, saturate
  function automatic logic signed [15:0] sat_round(input longint acc);
    longint q;
    q = (acc + longint'(32768)) >>> 16;
    if (q > 32767) begin
      q = 32767;
    end else if (q < -32768) begin
      q = -32768;
    end
    return 16'(q);
  endfunction

  // gains above unity act as unity
  function automatic longint clip_gain(input logic [16:0] g);
    return (g > sfd_pkg::UNITY) ? longint'(sfd_pkg::UNITY) : longint'(g);
  endfunction

  // zero length behaves as one, lengths past the store as the full store
  function automatic int unsigned active_len();
    if (len_reg == 16'd0) return 1;
    if (int'(len_reg) > MAX_DELAY) return MAX_DELAY;
    return int'(len_reg);
  endfunction

  // feed the sample back into its line and mix it with the oldest entry
  function automatic logic signed [15:0] predict_mix(input logic ch,
                                                     input logic signed [15:0] x);
    int unsigned        len;
    int unsigned        wr;
    int unsigned        rd;
    int unsigned        base;
    longint             fb;
    longint             dry;
    longint             acc;
    logic signed [15:0] delayed;
    len  = active_len();
    wr   = echo_pos[ch];
    if (wr >= len) wr = 0;
    base = int'(ch) * MAX_DELAY;
    fb   = clip_gain(fb_reg);
    dry  = clip_gain(dry_reg);
    acc  = (longint'(echo_store[base + wr]) + longint'(x)) * fb;
    echo_store[base + wr] = sat_round(acc);
    // with length one the read hits the entry just written
    rd = wr + 1;
    if (rd >= len) rd = 0;
    delayed = echo_store[base + rd];
    acc = longint'(delayed) * (longint'(sfd_pkg::UNITY) - dry) + longint'(x) * dry;
    echo_pos[ch] = rd;
    return sat_round(acc);
  endfunction

  always @(posedge clk) begin : watch
    logic signed [15:0] want;
    if (rst) begin
      foreach (echo_store[i]) echo_store[i] = '0;
      foreach (echo_pos[c]) echo_pos[c] = 0;
      len_reg = sfd_pkg::RST_DELAY_LEN;
      fb_reg  = sfd_pkg::RST_FEEDBACK;
      dry_reg = sfd_pkg::RST_DRY_MIX;
      mix_expected.delete();
      mismatch_count <= 0;
      outstanding    <= 0;
    end else begin
      // register transfer, unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sfd_pkg::REG_DELAY_LEN: begin
            len_reg = cfg_data[15:0];
            foreach (echo_pos[c]) echo_pos[c] = 0;
          end
          sfd_pkg::REG_FEEDBACK: begin
            fb_reg = cfg_data;
          end
          sfd_pkg::REG_DRY_MIX: begin
            dry_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
      // result transfer against the oldest prediction
      if (out_valid && out_ready) begin
        if (mix_expected.size() == 0) begin
          $error("sample_out: expected nothing, actual %0d", sample_out);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = mix_expected.pop_front();
          if (want !== sample_out) begin
            $error("sample_out: expected %0d, actual %0d", want, sample_out);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      // sample transfer
      if (in_valid && in_ready) begin
        mix_expected.push_back(predict_mix(chan, sample_in));
      end
      outstanding <= mix_expected.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the stereo feedback delay: a directed pass over the sample
// and gain extremes and the odd delay lengths, then random phases with fresh
// settings and changing sender and receiver pacing. Checking is left to the
// delay_mix_checker beside the block.
// ----------------------------------------------------------------------------
module tb;

  localparam int         MAX_DELAY     = 32768;
  localparam int         CHANNELS      = 2;
  localparam int         CYCLE_LIMIT   = 1_500_000;
  localparam int         RANDOM_PHASES = 17;
  localparam int         PHASE_ITEMS   = 100;
  localparam int         DRAIN_CYCLES  = 12;
  localparam logic [1:0] REG_UNUSED    = 2'd3;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               chan      = 1'b0;
  logic signed [15:0] sample_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] sample_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = sfd_pkg::REG_DELAY_LEN;
  logic [16:0]        cfg_data  = '0;

  int mismatch_count;
  int outstanding;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;

  stereo_feedback_delay_top #(
    .MAX_DELAY(MAX_DELAY),
    .CHANNELS (CHANNELS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .chan      (chan),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  delay_mix_checker #(
    .MAX_DELAY(MAX_DELAY),
    .CHANNELS (CHANNELS)
  ) mix_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .chan          (chan),
    .sample_in     (sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  // clock
  always #2 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** stereo_feedback_delay_top: FAILED **");
      $finish;
    end
  end

  // pacing of one phase: none, sender gaps, receiver stalls, both
  task automatic set_pace(input int mode);
    unique case (mode)
      1: begin
        idle_pct  = 48;
        stall_pct = 0;
      end
      2: begin
        idle_pct  = 0;
        stall_pct = 48;
      end
      3: begin
        idle_pct  = 29;
        stall_pct = 29;
      end
      default: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  // one sample transfer; valid is left high for a back-to-back successor
  task automatic send_sample(input logic ch, input logic signed [15:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    chan      <= ch;
    sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // one register transfer
  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and let every owed result arrive
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // samples leaning on the extremes
  function automatic logic signed [15:0] random_sample();
    unique case ($urandom_range(11))
      0:       return 16'sd32767;
      1:       return -16'sd32768;
      2:       return 16'($urandom_range(511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // gains including zero, unity and values past unity
  function automatic logic [16:0] random_gain();
    unique case ($urandom_range(5))
      0:       return 17'd0;
      1:       return sfd_pkg::UNITY;
      2:       return 17'($urandom);
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // mostly short lines so that the feedback wraps many times per phase
  function automatic logic [15:0] random_len();
    unique case ($urandom_range(19))
      0:       return 16'(MAX_DELAY);
      1:       return 16'($urandom);
      2:       return 16'd0;
      3, 4:    return 16'($urandom_range(1000, 17));
      default: return 16'($urandom_range(16, 1));
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // short line, unity feedback, fully delayed output: saturation in the loop
    set_pace(0);
    write_reg(sfd_pkg::REG_DELAY_LEN, 17'd4);
    write_reg(sfd_pkg::REG_FEEDBACK, sfd_pkg::UNITY);
    write_reg(sfd_pkg::REG_DRY_MIX, 17'd0);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b1, -16'sd32768);
    send_sample(1'b1, -16'sd32768);
    send_sample(1'b0, 16'sd0);
    send_sample(1'b0, -16'sd1);
    send_sample(1'b1, 16'sd1);
    send_sample(1'b1, 16'sd32767);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b0, -16'sd32768);
    wait_drained();

    // length one reads back its own write; gains past unity; unknown index
    write_reg(sfd_pkg::REG_DELAY_LEN, 17'd1);
    write_reg(sfd_pkg::REG_FEEDBACK, 17'h1FFFF);
    write_reg(sfd_pkg::REG_DRY_MIX, 17'h1FFFF);
    write_reg(REG_UNUSED, 17'h15555);
    send_sample(1'b0, -16'sd32768);
    send_sample(1'b1, 16'sd32767);
    send_sample(1'b0, 16'sd12345);
    send_sample(1'b1, -16'sd1);
    wait_drained();

    // zero length behaves as one, no feedback, almost fully delayed
    write_reg(sfd_pkg::REG_DELAY_LEN, 17'd0);
    write_reg(sfd_pkg::REG_FEEDBACK, 17'd0);
    write_reg(sfd_pkg::REG_DRY_MIX, 17'd1);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b1, -16'sd32768);
    send_sample(1'b0, -16'sd32768);
    wait_drained();

    // length past the store, gains just under unity, bit 16 of the data set
    write_reg(sfd_pkg::REG_DELAY_LEN, 17'h1FFFF);
    write_reg(sfd_pkg::REG_FEEDBACK, 17'd65535);
    write_reg(sfd_pkg::REG_DRY_MIX, 17'd65535);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b1, -16'sd32768);
    send_sample(1'b0, 16'sd100);
    wait_drained();

    // random phases with fresh settings and rotating pacing
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_pace(p % 4);
      write_reg(sfd_pkg::REG_DELAY_LEN, {1'($urandom), random_len()});
      write_reg(sfd_pkg::REG_FEEDBACK, random_gain());
      write_reg(sfd_pkg::REG_DRY_MIX, random_gain());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(1'($urandom), random_sample());
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("** stereo_feedback_delay_top: PASSED **");
    end else begin
      $display("** stereo_feedback_delay_top: FAILED **");
    end
    $finish;
  end

endmodule
